/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srts check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srts check failed");

`endif

/* hdl/srts_pkg.sv */
package srts_pkg;

	localparam int MAX_JOBS = 16;
	localparam int SLOT_W   = $clog2(MAX_JOBS);
	localparam int CNT_W    = SLOT_W + 1;
	localparam int TIME_W   = 16;
	localparam int BURST_W  = 16;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [TIME_W-1:0]  time_t;
	typedef logic [BURST_W-1:0] burst_t;

	localparam time_t TIME_MAX = '1;

	localparam logic KIND_ARRIVE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef logic [1:0] alu_op_t;
	localparam alu_op_t OP_LT  = 2'd0;
	localparam alu_op_t OP_INC = 2'd1;
	localparam alu_op_t OP_SUB = 2'd2;
	localparam alu_op_t OP_DEC = 2'd3;

	typedef struct packed {
		alu_op_t op;
		time_t   a;
		time_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  lt;
		time_t y;
	} alu_rsp_t;

	typedef struct packed {
		logic  accepted;
		slot_t slot;
		logic  ran;
		logic  done_res;
		time_t done_time;
		time_t done_turnaround;
		time_t done_wait;
	} res_t;

endpackage

/* hdl/srts_in_if.sv */
interface srts_in_if;
	logic             valid;
	logic             ready;
	logic             kind;
	srts_pkg::burst_t burst;

	modport source (output valid, output kind, output burst, input ready);
	modport sink (input valid, input kind, input burst, output ready);
endinterface

/* hdl/srts_out_if.sv */
interface srts_out_if;
	logic            valid;
	logic            ready;
	logic            accepted;
	srts_pkg::slot_t slot;
	logic            ran;
	logic            done_res;
	srts_pkg::time_t done_time;
	srts_pkg::time_t done_turnaround;
	srts_pkg::time_t done_wait;

	modport source (output valid, output accepted, output slot, output ran, output done_res,
		output done_time, output done_turnaround, output done_wait, input ready);
	modport sink (input valid, input accepted, input slot, input ran, input done_res,
		input done_time, input done_turnaround, input done_wait, output ready);
endinterface

/* hdl/srts_alu.sv */
module srts_alu (
	input  srts_pkg::alu_req_t req,
	output srts_pkg::alu_rsp_t rsp
);

	always_comb begin
		rsp.lt = (req.a < req.b);
		unique case (req.op)
			srts_pkg::OP_LT:  rsp.y = req.a;
			srts_pkg::OP_INC: rsp.y = (req.a == srts_pkg::TIME_MAX) ? req.a : req.a + 1'b1;
			srts_pkg::OP_SUB: rsp.y = req.a - req.b;
			srts_pkg::OP_DEC: rsp.y = req.a - 1'b1;
		endcase
	end

endmodule

/* hdl/shortest_remaining_time_scheduler_core.sv */
// Arrival: ST_IDLE goes straight to ST_OUT, which loads the result register.
// Tick with a ready job: ST_SCAN, ST_SEL, ST_WUPD, ST_FETCH, ST_FIN1, ST_FIN2 and ST_OUT,
// taking one slot per cycle through the shared compare/increment unit: a minimum scan, then a
// wait-update pass. Idle tick: ST_SCAN, ST_SEL, ST_FIN1, ST_FIN2 and ST_OUT. Input is ready
// again once the result register loads; a held result stalls that load. One item in flight.
// arst_n clears control state and the remaining-time table; arrival and wait
// memories are not cleared and their values are only used for slots that hold a job.
module shortest_remaining_time_scheduler_core (
	input logic        clk,
	input logic        arst_n,
	srts_in_if.sink    item,
	srts_out_if.source result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SEL   = 3'd2;
	localparam logic [2:0] ST_WUPD  = 3'd3;
	localparam logic [2:0] ST_FETCH = 3'd4;
	localparam logic [2:0] ST_FIN1  = 3'd5;
	localparam logic [2:0] ST_FIN2  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]             state_q;
	srts_pkg::cnt_t         idx_q;
	srts_pkg::slot_t        idx_lo;
	logic                   found_q;
	srts_pkg::time_t        cur_q;
	srts_pkg::slot_t        run_slot_q;
	logic                   run_valid_q;
	srts_pkg::cnt_t         slots_used_q;
	logic                   out_valid_q;
	logic                   upd_en_s1;

	srts_pkg::time_t        rem_q [srts_pkg::MAX_JOBS];
	srts_pkg::time_t        arr_mem [srts_pkg::MAX_JOBS];
	srts_pkg::time_t        wait_mem [srts_pkg::MAX_JOBS];

	srts_pkg::slot_t        best_q;
	srts_pkg::time_t        best_rem_q;
	srts_pkg::time_t        run_rem_q;
	srts_pkg::time_t        wait_rd_q;
	srts_pkg::time_t        arr_rd_q;
	srts_pkg::slot_t        upd_idx_s1;
	logic                   done_q;
	srts_pkg::time_t        dtime_q;
	srts_pkg::res_t         res_q;
	srts_pkg::res_t         out_q;

	srts_pkg::alu_req_t     alu_req;
	srts_pkg::alu_rsp_t     alu_rsp;

	logic                   in_acc;
	logic                   arr_ok;
	logic                   out_load;
	srts_pkg::time_t        scan_rem;
	srts_pkg::slot_t        new_slot;

	assign idx_lo   = idx_q[srts_pkg::SLOT_W-1:0];
	assign scan_rem = rem_q[idx_lo];
	assign new_slot = slots_used_q[srts_pkg::SLOT_W-1:0];

	assign item.ready = (state_q == ST_IDLE);
	assign in_acc     = item.valid && item.ready;
	assign arr_ok     = (item.kind == srts_pkg::KIND_ARRIVE)
		&& (slots_used_q < srts_pkg::cnt_t'(srts_pkg::MAX_JOBS))
		&& (item.burst != '0);
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	srts_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_SCAN: begin
				alu_req.op = srts_pkg::OP_LT;
				alu_req.a  = scan_rem;
				alu_req.b  = best_rem_q;
			end
			ST_WUPD: begin
				alu_req.op = srts_pkg::OP_INC;
				alu_req.a  = wait_rd_q;
			end
			ST_FETCH: begin
				alu_req.op = srts_pkg::OP_DEC;
				alu_req.a  = best_rem_q;
			end
			ST_FIN1: begin
				alu_req.op = srts_pkg::OP_INC;
				alu_req.a  = cur_q;
			end
			ST_FIN2: begin
				alu_req.op = srts_pkg::OP_SUB;
				alu_req.a  = dtime_q;
				alu_req.b  = arr_rd_q;
			end
			default: alu_req = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			cur_q        <= '0;
			run_slot_q   <= '0;
			run_valid_q  <= 1'b0;
			slots_used_q <= '0;
			upd_en_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (item.kind == srts_pkg::KIND_ARRIVE) begin
							if (arr_ok) slots_used_q <= slots_used_q + 1'b1;
							state_q <= ST_OUT;
						end else begin
							found_q <= 1'b0;
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_rem != '0) found_q <= 1'b1;
					if (idx_q == srts_pkg::cnt_t'(srts_pkg::MAX_JOBS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_SEL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SEL: begin
					upd_en_s1 <= 1'b0;
					state_q   <= found_q ? ST_WUPD : ST_FIN1;
				end
				ST_WUPD: begin
					if (idx_q == srts_pkg::cnt_t'(srts_pkg::MAX_JOBS)) begin
						upd_en_s1 <= 1'b0;
						state_q   <= ST_FETCH;
					end else begin
						upd_en_s1 <= (idx_lo != best_q) && (scan_rem != '0);
						idx_q     <= idx_q + 1'b1;
					end
				end
				ST_FETCH: state_q <= ST_FIN1;
				ST_FIN1: begin
					cur_q <= alu_rsp.y;
					if (found_q) begin
						run_slot_q  <= best_q;
						run_valid_q <= !done_q;
					end
					state_q <= ST_FIN2;
				end
				ST_FIN2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// remaining-time table, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srts_pkg::MAX_JOBS; i++) rem_q[i] <= '0;
		end else if (state_q == ST_IDLE && in_acc && arr_ok) begin
			rem_q[new_slot] <= srts_pkg::time_t'(item.burst);
		end else if (state_q == ST_FETCH) begin
			rem_q[best_q] <= alu_rsp.y;
		end
	end

	// arrival and wait memories
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && arr_ok) begin
			arr_mem[new_slot]  <= cur_q;
			wait_mem[new_slot] <= '0;
		end else if (state_q == ST_WUPD && upd_en_s1) begin
			wait_mem[upd_idx_s1] <= alu_rsp.y;
		end
		if (state_q == ST_WUPD && idx_q != srts_pkg::cnt_t'(srts_pkg::MAX_JOBS)) begin
			wait_rd_q <= wait_mem[idx_lo];
		end else if (state_q == ST_FETCH) begin
			wait_rd_q <= wait_mem[best_q];
		end
		if (state_q == ST_FETCH) arr_rd_q <= arr_mem[best_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && item.kind == srts_pkg::KIND_ARRIVE) begin
					res_q.accepted        <= arr_ok;
					res_q.slot            <= arr_ok ? new_slot : '0;
					res_q.ran             <= 1'b0;
					res_q.done_res        <= 1'b0;
					res_q.done_time       <= '0;
					res_q.done_turnaround <= '0;
					res_q.done_wait       <= '0;
				end
			end
			ST_SCAN: begin
				if (scan_rem != '0 && (!found_q || alu_rsp.lt)) begin
					best_q     <= idx_lo;
					best_rem_q <= scan_rem;
				end
				if (idx_lo == run_slot_q) run_rem_q <= scan_rem;
			end
			ST_SEL: begin
				// running job keeps the processor on a tie
				if (run_valid_q && run_rem_q != '0 && run_rem_q == best_rem_q)
					best_q <= run_slot_q;
			end
			ST_WUPD: upd_idx_s1 <= idx_lo;
			ST_FETCH: done_q <= (alu_rsp.y == '0);
			ST_FIN1: dtime_q <= alu_rsp.y;
			ST_FIN2: begin
				res_q.accepted        <= 1'b0;
				res_q.slot            <= found_q ? best_q : '0;
				res_q.ran             <= found_q;
				res_q.done_res        <= found_q && done_q;
				res_q.done_time       <= (found_q && done_q) ? dtime_q : '0;
				res_q.done_turnaround <= (found_q && done_q) ? alu_rsp.y : '0;
				res_q.done_wait       <= (found_q && done_q) ? wait_rd_q : '0;
			end
			default: ;
		endcase
		if (out_load) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.accepted        = out_q.accepted;
	assign result.slot            = out_q.slot;
	assign result.ran             = out_q.ran;
	assign result.done_res        = out_q.done_res;
	assign result.done_time       = out_q.done_time;
	assign result.done_turnaround = out_q.done_turnaround;
	assign result.done_wait       = out_q.done_wait;

endmodule

/* hdl/srts_checker.sv */
`include "assert_macros.svh"

module srts_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic            accepted,
	input logic            ran,
	input logic            done_res,
	input srts_pkg::time_t done_time,
	input srts_pkg::time_t done_turnaround,
	input srts_pkg::time_t done_wait
);

	// one transaction at a time: ready drops after an accept
	`SRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`SRTS_ASSERT_SAME(a_done_needs_ran, out_valid && done_res, ran)
	`SRTS_ASSERT_SAME(a_arrival_not_run, out_valid && accepted, !ran && !done_res)
	`SRTS_ASSERT_SAME(a_stats_zero, out_valid && !done_res,
		done_time == '0 && done_turnaround == '0 && done_wait == '0)
	`SRTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(done_time) && $stable(ran))

endmodule

bind shortest_remaining_time_scheduler_core srts_checker u_srts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.accepted(result.accepted),
	.ran(result.ran),
	.done_res(result.done_res),
	.done_time(result.done_time),
	.done_turnaround(result.done_turnaround),
	.done_wait(result.done_wait)
);
